// ===== src/kshi_pkg.sv =====
`timescale 1ns / 1ps
// kshi_pkg: shared types and constants for the k-line slow-init handshake block
package kshi_pkg;

    localparam int unsigned TICK_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CFG_IDX_W = 3;

    localparam logic [TICK_W-1:0] TICK_MAX    = 16'hFFFF;
    localparam logic [BYTE_W-1:0] SYNC_BYTE   = 8'h55;
    localparam logic [3:0]        BIT_COUNT   = 4'd10;
    localparam logic [1:0]        KEY_BYTE_NO = 2'd2;

    localparam logic [TICK_W-1:0] RST_PRE_DELAY     = 16'd300;
    localparam logic [TICK_W-1:0] RST_BIT_TICKS     = 16'd200;
    localparam logic [TICK_W-1:0] RST_SYNC_WINDOW   = 16'd1600;
    localparam logic [TICK_W-1:0] RST_CONFIRM_WIN   = 16'd1200;
    localparam logic [BYTE_W-1:0] RST_INIT_ADDRESS  = 8'h16;
    localparam logic [BYTE_W-1:0] RST_CONFIRM_VALUE = 8'hE9;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_START = 2'd2,
        OP_ABORT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ABORTED    = 2'd1,
        ST_NO_KEY     = 2'd2,
        ST_NO_CONFIRM = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRE     = 3'd1,
        PH_BITS    = 3'd2,
        PH_SYNC    = 3'd3,
        PH_CONFIRM = 3'd4
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRE_DELAY     = 3'd0,
        CFG_BIT_TICKS     = 3'd1,
        CFG_SYNC_WINDOW   = 3'd2,
        CFG_CONFIRM_WIN   = 3'd3,
        CFG_INIT_ADDRESS  = 3'd4,
        CFG_CONFIRM_VALUE = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [TICK_W-1:0] pre_delay_ticks;
        logic [TICK_W-1:0] bit_ticks;
        logic [TICK_W-1:0] sync_window_ticks;
        logic [TICK_W-1:0] confirm_window_ticks;
        logic [BYTE_W-1:0] init_address;
        logic [BYTE_W-1:0] confirm_value;
    } cfg_t;

    // msb first, so line_active sits in bit 0 when packed
    typedef struct packed {
        status_t           status;
        logic              done_res;
        logic              busy_res;
        logic [BYTE_W-1:0] tx_byte;
        logic              tx_valid;
        logic              line_active;
    } result_t;

endpackage

// ===== src/kshi_cfg_regs.sv =====
`timescale 1ns / 1ps
// kshi_cfg_regs: configuration register file with reset defaults
module kshi_cfg_regs (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              wr_en,
    input  logic [kshi_pkg::CFG_IDX_W-1:0]    wr_index,
    input  logic [kshi_pkg::TICK_W-1:0]       wr_data,
    output kshi_pkg::cfg_t                    cfg
);

    kshi_pkg::cfg_t cfg_reg;
    kshi_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (kshi_pkg::cfg_idx_t'(wr_index))
                kshi_pkg::CFG_PRE_DELAY:     cfg_next.pre_delay_ticks      = wr_data;
                kshi_pkg::CFG_BIT_TICKS:     cfg_next.bit_ticks            = wr_data;
                kshi_pkg::CFG_SYNC_WINDOW:   cfg_next.sync_window_ticks    = wr_data;
                kshi_pkg::CFG_CONFIRM_WIN:   cfg_next.confirm_window_ticks = wr_data;
                kshi_pkg::CFG_INIT_ADDRESS:
                    cfg_next.init_address  = wr_data[kshi_pkg::BYTE_W-1:0];
                kshi_pkg::CFG_CONFIRM_VALUE:
                    cfg_next.confirm_value = wr_data[kshi_pkg::BYTE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pre_delay_ticks      <= kshi_pkg::RST_PRE_DELAY;
            cfg_reg.bit_ticks            <= kshi_pkg::RST_BIT_TICKS;
            cfg_reg.sync_window_ticks    <= kshi_pkg::RST_SYNC_WINDOW;
            cfg_reg.confirm_window_ticks <= kshi_pkg::RST_CONFIRM_WIN;
            cfg_reg.init_address         <= kshi_pkg::RST_INIT_ADDRESS;
            cfg_reg.confirm_value        <= kshi_pkg::RST_CONFIRM_VALUE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/kshi_core.sv =====
`timescale 1ns / 1ps
// kshi_core: handshake sequencer state and per-item next-state logic
module kshi_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step_en,
    input  kshi_pkg::op_t                op,
    input  logic [kshi_pkg::BYTE_W-1:0]  rx_byte,
    input  kshi_pkg::cfg_t               cfg,
    output kshi_pkg::result_t            res
);

    kshi_pkg::phase_t            phase_reg, phase_next;
    logic [kshi_pkg::TICK_W-1:0] tick_count_reg, tick_count_next;
    logic [3:0]                  bit_index_reg, bit_index_next;
    logic                        sync_seen_reg, sync_seen_next;
    logic [1:0]                  bytes_after_sync_reg, bytes_after_sync_next;
    logic                        line_level_reg, line_level_next;

    logic [kshi_pkg::TICK_W-1:0] tick_inc;
    logic [kshi_pkg::TICK_W-1:0] bit_len;
    logic [3:0]                  bit_plus;
    logic [1:0]                  bytes_plus;
    logic                        done;
    kshi_pkg::status_t           status;
    logic                        tx_valid;
    logic [kshi_pkg::BYTE_W-1:0] tx_byte;

    // line level for slow bit idx: start low, data lsb first, stop high
    function automatic logic bit_level(input logic [3:0] idx,
                                       input logic [kshi_pkg::BYTE_W-1:0] addr);
        logic [2:0] sel;
        logic       lvl;
        sel = 3'(idx - 4'd1);
        if (idx == 4'd0) begin
            lvl = 1'b0;
        end else if (idx <= 4'd8) begin
            lvl = addr[sel];
        end else begin
            lvl = 1'b1;
        end
        return lvl;
    endfunction

    assign tick_inc   = (tick_count_reg == kshi_pkg::TICK_MAX) ? tick_count_reg
                                                               : tick_count_reg + 16'd1;
    assign bit_len    = cfg.bit_ticks | {15'd0, (cfg.bit_ticks == 16'd0)};
    assign bit_plus   = bit_index_reg + 4'd1;
    assign bytes_plus = bytes_after_sync_reg + 2'd1;

    always_comb begin
        phase_next            = phase_reg;
        tick_count_next       = tick_count_reg;
        bit_index_next        = bit_index_reg;
        sync_seen_next        = sync_seen_reg;
        bytes_after_sync_next = bytes_after_sync_reg;
        line_level_next       = line_level_reg;
        done                  = 1'b0;
        status                = kshi_pkg::ST_OK;
        tx_valid              = 1'b0;
        tx_byte               = '0;

        case (op)
            kshi_pkg::OP_START: begin
                if (phase_reg == kshi_pkg::PH_IDLE) begin
                    tick_count_next       = '0;
                    bit_index_next        = '0;
                    sync_seen_next        = 1'b0;
                    bytes_after_sync_next = '0;
                    if (cfg.pre_delay_ticks == 16'd0) begin
                        phase_next      = kshi_pkg::PH_BITS;
                        line_level_next = 1'b0;
                    end else begin
                        phase_next      = kshi_pkg::PH_PRE;
                        line_level_next = 1'b1;
                    end
                end
            end
            kshi_pkg::OP_ABORT: begin
                if (phase_reg != kshi_pkg::PH_IDLE) begin
                    done   = 1'b1;
                    status = kshi_pkg::ST_ABORTED;
                end
            end
            kshi_pkg::OP_TICK: begin
                case (phase_reg)
                    kshi_pkg::PH_PRE: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= cfg.pre_delay_ticks) begin
                            phase_next      = kshi_pkg::PH_BITS;
                            tick_count_next = '0;
                            bit_index_next  = '0;
                            line_level_next = 1'b0;
                        end
                    end
                    kshi_pkg::PH_BITS: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= bit_len) begin
                            tick_count_next = '0;
                            if (bit_plus >= kshi_pkg::BIT_COUNT) begin
                                bit_index_next        = '0;
                                line_level_next       = 1'b1;
                                phase_next            = kshi_pkg::PH_SYNC;
                                sync_seen_next        = 1'b0;
                                bytes_after_sync_next = '0;
                            end else begin
                                bit_index_next  = bit_plus;
                                line_level_next = bit_level(bit_plus, cfg.init_address);
                            end
                        end
                    end
                    kshi_pkg::PH_SYNC: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= cfg.sync_window_ticks) begin
                            done   = 1'b1;
                            status = kshi_pkg::ST_NO_KEY;
                        end
                    end
                    kshi_pkg::PH_CONFIRM: begin
                        tick_count_next = tick_inc;
                        if (tick_inc >= cfg.confirm_window_ticks) begin
                            done   = 1'b1;
                            status = kshi_pkg::ST_NO_CONFIRM;
                        end
                    end
                    default: begin
                        tick_count_next = tick_count_reg;
                    end
                endcase
            end
            kshi_pkg::OP_BYTE: begin
                if (phase_reg == kshi_pkg::PH_SYNC) begin
                    if (!sync_seen_reg) begin
                        if (rx_byte == kshi_pkg::SYNC_BYTE) begin
                            sync_seen_next        = 1'b1;
                            bytes_after_sync_next = '0;
                        end
                    end else begin
                        bytes_after_sync_next = bytes_plus;
                        if (bytes_plus >= kshi_pkg::KEY_BYTE_NO) begin
                            tx_valid        = 1'b1;
                            tx_byte         = ~rx_byte;
                            phase_next      = kshi_pkg::PH_CONFIRM;
                            tick_count_next = '0;
                        end
                    end
                end else if (phase_reg == kshi_pkg::PH_CONFIRM) begin
                    if (rx_byte == cfg.confirm_value) begin
                        done   = 1'b1;
                        status = kshi_pkg::ST_OK;
                    end
                end
            end
            default: begin
                done = 1'b0;
            end
        endcase

        if (done) begin
            phase_next            = kshi_pkg::PH_IDLE;
            tick_count_next       = '0;
            bit_index_next        = '0;
            sync_seen_next        = 1'b0;
            bytes_after_sync_next = '0;
            line_level_next       = 1'b1;
        end

        res.line_active = ~line_level_next;
        res.tx_valid    = tx_valid;
        res.tx_byte     = tx_byte;
        res.busy_res    = (phase_next != kshi_pkg::PH_IDLE);
        res.done_res    = done;
        res.status      = status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg            <= kshi_pkg::PH_IDLE;
            tick_count_reg       <= '0;
            bit_index_reg        <= '0;
            sync_seen_reg        <= 1'b0;
            bytes_after_sync_reg <= '0;
            line_level_reg       <= 1'b1;
        end else if (step_en) begin
            phase_reg            <= phase_next;
            tick_count_reg       <= tick_count_next;
            bit_index_reg        <= bit_index_next;
            sync_seen_reg        <= sync_seen_next;
            bytes_after_sync_reg <= bytes_after_sync_next;
            line_level_reg       <= line_level_next;
        end
    end

endmodule

// ===== src/kline_slow_init_handshake_top.sv =====
`timescale 1ns / 1ps
// kline_slow_init_handshake_top: k-line 5-baud slow-init handshake, stream top level
//
// Each input item (tick, received byte, start or abort) yields exactly one result item.
// An item waits in the input register, the sequencer updates its state as the
// item moves into the output register, and the result is offered on the next cycle.
// One item per cycle is sustained while m_tready stays high.
// Configuration writes are always accepted and take effect once registered; write only while idle.
module kline_slow_init_handshake_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic [1:0]  s_tuser,   // op[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // line_active, tx_valid, tx_byte[7:0], busy_res,
                                   // done_res, status[1:0], zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                        in_valid_reg;
    kshi_pkg::op_t               in_op_reg;
    logic [kshi_pkg::BYTE_W-1:0] in_rx_reg;
    logic                        out_valid_reg;
    kshi_pkg::result_t           out_res_reg;

    logic              advance;
    logic              s_accept;
    kshi_pkg::cfg_t    cfg;
    kshi_pkg::result_t core_res;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    kshi_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    kshi_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (advance),
        .op      (in_op_reg),
        .rx_byte (in_rx_reg),
        .cfg     (cfg),
        .res     (core_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_op_reg <= kshi_pkg::op_t'(s_tuser);
            in_rx_reg <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_res_reg};

    // an item that moves on always lands in the output register
    a_advance_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_valid_reg)
        else $error("advanced item missing from output register");

    // the input register never takes an item over one that has not moved on
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_accept && in_valid_reg && !advance))
        else $error("input item overwritten");

    // a finished run leaves the line released and the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.done_res) |->
            (!out_res_reg.busy_res && !out_res_reg.line_active && !out_res_reg.tx_valid))
        else $error("done result with busy, break or transmit set");

    // the key reply goes out only in a running run with the line released
    a_tx_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.tx_valid) |->
            (out_res_reg.busy_res && !out_res_reg.line_active))
        else $error("key reply outside a running handshake");

endmodule

// ===== dv/kshi_checker.sv =====
`timescale 1ns / 1ps
// kshi_checker: predicts every result item of the k-line slow-init block and compares it
module kshi_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          outstanding
);
    import kshi_pkg::*;

    localparam logic [15:0] DEF_PRE_DELAY   = 16'd300;
    localparam logic [15:0] DEF_BIT_LEN     = 16'd200;
    localparam logic [15:0] DEF_SYNC_WIN    = 16'd1600;
    localparam logic [15:0] DEF_CONFIRM_WIN = 16'd1200;
    localparam logic [7:0]  DEF_ADDRESS     = 8'h16;
    localparam logic [7:0]  DEF_CONFIRM     = 8'hE9;

    logic [15:0] pre_delay;
    logic [15:0] bit_len;
    logic [15:0] sync_win;
    logic [15:0] confirm_win;
    logic [7:0]  address;
    logic [7:0]  confirm_byte;

    phase_t      ph;
    logic [15:0] ticks;
    logic [3:0]  bit_no;
    logic        synced;
    logic [1:0]  after_sync;
    logic        line_high;

    result_t     expected_q[$];
    int          failures = 0;

    assign fail_count = failures;

    function automatic logic address_level(logic [3:0] idx);
        if (idx == 4'd0) return 1'b0;
        if (idx <= 4'd8) return address[idx - 4'd1];
        return 1'b1;
    endfunction

    function automatic void tick_up();
        if (ticks != 16'hFFFF) ticks = ticks + 16'd1;
    endfunction

    function automatic void clear_run();
        ph = PH_IDLE;
        ticks = '0;
        bit_no = '0;
        synced = 1'b0;
        after_sync = '0;
        line_high = 1'b1;
    endfunction

    function automatic void begin_bits();
        ph = PH_BITS;
        ticks = '0;
        bit_no = '0;
        line_high = address_level(4'd0);
    endfunction

    function automatic result_t predict_result(op_t op, logic [7:0] rx);
        result_t     r;
        logic [15:0] span;
        r = '0;
        span = (bit_len == 16'd0) ? 16'd1 : bit_len;
        case (op)
            OP_START: begin
                if (ph == PH_IDLE) begin
                    clear_run();
                    if (pre_delay == 16'd0) begin_bits();
                    else ph = PH_PRE;
                end
            end
            OP_ABORT: begin
                if (ph != PH_IDLE) begin
                    r.done_res = 1'b1;
                    r.status = ST_ABORTED;
                end
            end
            OP_TICK: begin
                case (ph)
                    PH_PRE: begin
                        tick_up();
                        if (ticks >= pre_delay) begin_bits();
                    end
                    PH_BITS: begin
                        tick_up();
                        if (ticks >= span) begin
                            ticks = '0;
                            bit_no = bit_no + 4'd1;
                            if (bit_no >= 4'd10) begin
                                bit_no = '0;
                                line_high = 1'b1;
                                ph = PH_SYNC;
                                synced = 1'b0;
                                after_sync = '0;
                            end else begin
                                line_high = address_level(bit_no);
                            end
                        end
                    end
                    PH_SYNC: begin
                        tick_up();
                        if (ticks >= sync_win) begin
                            r.done_res = 1'b1;
                            r.status = ST_NO_KEY;
                        end
                    end
                    PH_CONFIRM: begin
                        tick_up();
                        if (ticks >= confirm_win) begin
                            r.done_res = 1'b1;
                            r.status = ST_NO_CONFIRM;
                        end
                    end
                    default: ;
                endcase
            end
            OP_BYTE: begin
                if (ph == PH_SYNC) begin
                    if (!synced) begin
                        if (rx == SYNC_BYTE) begin
                            synced = 1'b1;
                            after_sync = '0;
                        end
                    end else begin
                        after_sync = after_sync + 2'd1;
                        if (after_sync >= 2'd2) begin
                            r.tx_valid = 1'b1;
                            r.tx_byte = ~rx;
                            ph = PH_CONFIRM;
                            ticks = '0;
                        end
                    end
                end else if (ph == PH_CONFIRM && rx == confirm_byte) begin
                    r.done_res = 1'b1;
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        if (r.done_res) clear_run();
        r.line_active = ~line_high;
        r.busy_res = (ph != PH_IDLE);
        return r;
    endfunction

    function automatic void report_field(string name, logic [7:0] want, logic [7:0] got);
        failures++;
        $display("%0t ns: %s expected %0h got %0h", $time, name, want, got);
    endfunction

    always @(posedge aclk) begin : watch
        result_t got;
        result_t want;
        if (!aresetn) begin
            pre_delay = DEF_PRE_DELAY;
            bit_len = DEF_BIT_LEN;
            sync_win = DEF_SYNC_WIN;
            confirm_win = DEF_CONFIRM_WIN;
            address = DEF_ADDRESS;
            confirm_byte = DEF_CONFIRM;
            clear_run();
            expected_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_PRE_DELAY:     pre_delay = cfg_data;
                    CFG_BIT_TICKS:     bit_len = cfg_data;
                    CFG_SYNC_WINDOW:   sync_win = cfg_data;
                    CFG_CONFIRM_WIN:   confirm_win = cfg_data;
                    CFG_INIT_ADDRESS:  address = cfg_data[7:0];
                    CFG_CONFIRM_VALUE: confirm_byte = cfg_data[7:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[$bits(result_t)-1:0]);
                if (expected_q.size() == 0) begin
                    failures++;
                    $display("%0t ns: unexpected result item %h", $time, m_tdata);
                end else begin
                    want = expected_q.pop_front();
                    if (got.line_active !== want.line_active)
                        report_field("line_active", 8'(want.line_active),
                                     8'(got.line_active));
                    if (got.tx_valid !== want.tx_valid)
                        report_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
                    if (got.tx_byte !== want.tx_byte)
                        report_field("tx_byte", want.tx_byte, got.tx_byte);
                    if (got.busy_res !== want.busy_res)
                        report_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
                    if (got.done_res !== want.done_res)
                        report_field("done_res", 8'(want.done_res), 8'(got.done_res));
                    if (got.status !== want.status)
                        report_field("status", 8'(want.status), 8'(got.status));
                    if (m_tdata[15:$bits(result_t)] !== '0)
                        report_field("pad", 8'h00, 8'(m_tdata[15:$bits(result_t)]));
                end
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(predict_result(op_t'(s_tuser), s_tdata));
        end
        outstanding <= expected_q.size();
    end

endmodule

// ===== dv/tb_kline_slow_init_handshake_top.sv =====
`timescale 1ns / 1ps
// tb_kline_slow_init_handshake_top: stimulus and verdict for the k-line slow-init block
module tb_kline_slow_init_handshake_top;
    import kshi_pkg::*;

    localparam int ITEM_TARGET = 1050;
    localparam int PHASES      = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int TIMEOUT_CAP = 64;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = OP_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    int fail_count;
    int outstanding;
    bit idle_on = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int items_sent = 0;
    int sessions = 0;
    int configs = 0;

    logic [15:0] cur_pre;
    logic [15:0] cur_bit;
    logic [15:0] cur_sync;
    logic [15:0] cur_conf;
    logic [7:0]  cur_confv;

    always #2 aclk = ~aclk;

    kline_slow_init_handshake_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    kshi_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // result side backpressure
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 10);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("no item moved for %0d cycles", quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] non_sync_byte();
        logic [7:0] b;
        b = pick_byte();
        if (b == SYNC_BYTE) b = ~b;
        return b;
    endfunction

    function automatic logic [7:0] non_confirm_byte();
        logic [7:0] b;
        b = pick_byte();
        if (b == cur_confv) b = ~b;
        return b;
    endfunction

    task automatic send_item(input op_t op, input logic [7:0] rx);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= rx;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic setup(input logic [15:0] pre, input logic [15:0] bit_len,
                         input logic [15:0] sync_win, input logic [15:0] conf_win,
                         input logic [7:0] addr, input logic [7:0] confv);
        send_item(OP_ABORT, pick_byte());
        drain();
        repeat (4) @(posedge aclk);
        for (int i = CFG_CONFIRM_VALUE + 1; i < (1 << CFG_IDX_W); i++)
            cfg_write(3'(i), 16'($urandom));
        cfg_write(CFG_PRE_DELAY, pre);
        cfg_write(CFG_BIT_TICKS, bit_len);
        cfg_write(CFG_SYNC_WINDOW, sync_win);
        cfg_write(CFG_CONFIRM_WIN, conf_win);
        cfg_write(CFG_INIT_ADDRESS, {8'($urandom), addr});
        cfg_write(CFG_CONFIRM_VALUE, {8'($urandom), confv});
        cfg_valid <= 1'b0;
        cur_pre = pre;
        cur_bit = bit_len;
        cur_sync = sync_win;
        cur_conf = conf_win;
        cur_confv = confv;
        configs++;
    endtask

    task automatic send_ticks(input int n, input bit noisy);
        repeat (n) begin
            if (noisy && $urandom_range(0, 7) == 0) send_item(OP_BYTE, pick_byte());
            send_item(OP_TICK, pick_byte());
        end
    endtask

    task automatic end_by_timeout(input int window);
        if (window > TIMEOUT_CAP) send_item(OP_ABORT, pick_byte());
        else send_ticks(window, 1'b0);
    endtask

    // one handshake attempt, mostly well formed, ending in every possible way
    task automatic run_session();
        int         fate;
        int         span;
        logic [7:0] key;
        fate = $urandom_range(0, 11);
        span = (cur_bit == 16'd0) ? 1 : int'(cur_bit);
        send_item(OP_START, pick_byte());
        if ($urandom_range(0, 5) == 0) send_item(OP_START, pick_byte());
        if (fate == 11) begin
            send_ticks($urandom_range(0, int'(cur_pre) + 10 * span), 1'b1);
            send_item(OP_ABORT, pick_byte());
            return;
        end
        send_ticks(int'(cur_pre) + 10 * span, 1'b1);
        repeat ($urandom_range(0, 3)) begin
            if ($urandom_range(0, 2) == 0) send_item(OP_TICK, pick_byte());
            send_item(OP_BYTE, non_sync_byte());
        end
        if (fate == 10) begin
            if ($urandom_range(0, 1) == 0) begin
                send_item(OP_BYTE, SYNC_BYTE);
                send_item(OP_BYTE, pick_byte());
            end
            end_by_timeout(int'(cur_sync));
            return;
        end
        send_item(OP_BYTE, SYNC_BYTE);
        if ($urandom_range(0, 2) == 0) send_item(OP_TICK, pick_byte());
        send_item(OP_BYTE, pick_byte());
        key = pick_byte();
        send_item(OP_BYTE, key);
        if ($urandom_range(0, 4) == 0) drain();
        if (fate == 8) begin
            send_item(OP_ABORT, pick_byte());
            return;
        end
        send_item(OP_BYTE, ~key);
        repeat ($urandom_range(0, 2)) begin
            if ($urandom_range(0, 1) == 0) send_item(OP_TICK, pick_byte());
            send_item(OP_BYTE, non_confirm_byte());
        end
        if (fate == 9) end_by_timeout(int'(cur_conf));
        else send_item(OP_BYTE, cur_confv);
        if ($urandom_range(0, 3) == 0) send_item(OP_ABORT, pick_byte());
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero delays and sync window, items while idle and while sending bits
        setup(16'd0, 16'd0, 16'd0, 16'd1, 8'hA5, 8'h5A);
        send_item(OP_TICK, 8'h00);
        send_item(OP_BYTE, 8'hFF);
        send_item(OP_START, 8'h00);
        send_item(OP_START, 8'hFF);
        send_item(OP_BYTE, SYNC_BYTE);
        send_ticks(10, 1'b0);
        send_item(OP_TICK, 8'hFF);

        // largest settings, abort mid-run
        setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        send_item(OP_START, 8'h55);
        send_item(OP_TICK, 8'hAA);
        send_item(OP_ABORT, 8'h00);

        for (int p = 0; p < PHASES; p++) begin
            idle_on <= (p != 3) && (p < PHASES - 2);
            case (p)
                0: setup(16'd0, 16'd0, 16'd0, 16'd0, pick_byte(), pick_byte());
                1: setup(16'($urandom_range(0, 6)), 16'($urandom_range(1, 3)),
                         16'hFFFF, 16'hFFFF, 8'h00, 8'hFF);
                2: setup(16'($urandom_range(0, 6)), 16'($urandom_range(0, 3)),
                         16'($urandom_range(3, 12)), 16'($urandom_range(2, 8)),
                         8'hFF, 8'h00);
                default: setup(16'($urandom_range(0, 8)), 16'($urandom_range(0, 3)),
                               16'($urandom_range(1, 24)), 16'($urandom_range(1, 16)),
                               pick_byte(), pick_byte());
            endcase
            while (items_sent < (p + 1) * ITEM_TARGET / PHASES) begin
                run_session();
                sessions++;
            end
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("ran %0d input items over %0d handshakes and %0d register settings",
                 items_sent, sessions, configs);
        if (fail_count == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
